// ===== hw/rtl/fuzzy_clutter_likelihood_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared property forms for the fuzzy clutter likelihood block.
// ---------------------------------------------------------------------------
`ifndef FUZZY_CLUTTER_LIKELIHOOD_ASSERT_SVH
`define FUZZY_CLUTTER_LIKELIHOOD_ASSERT_SVH

// same-cycle implication
`define FCL_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/fcl_pkg.sv =====
// ---------------------------------------------------------------------------
// fcl_pkg
// Widths, constants and shared types of the fuzzy clutter likelihood block.
// ---------------------------------------------------------------------------
`default_nettype none

package fcl_pkg;

   localparam int FEATURE_WIDTH         = 24;
   localparam int FEATURE_FRACTION_BITS = 12;

   localparam int NUM_FEATURES  = 6;
   localparam int SETTING_WIDTH = 64;
   localparam int LEVEL_WIDTH   = 24;
   localparam int WEIGHT_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = $clog2(NUM_FEATURES);

   localparam int FIFTY_LEVEL = 50 * (2 ** FEATURE_FRACTION_BITS);
   localparam int SMALL_LIMIT = (2 ** FEATURE_FRACTION_BITS) / 100;

   // magnitude of any transformed feature fits in VALUE_WIDTH bits
   localparam int VALUE_WIDTH = (FEATURE_WIDTH > FEATURE_FRACTION_BITS + 6) ?
                                FEATURE_WIDTH + 1 : FEATURE_FRACTION_BITS + 7;
   localparam int VAL_W  = VALUE_WIDTH + 1;
   localparam int DIFF_W = ((VAL_W > LEVEL_WIDTH) ? VAL_W : LEVEL_WIDTH) + 1;
   localparam int SPAN_W = LEVEL_WIDTH + 1;

   localparam int QUOTIENT_BITS = 16;
   localparam int MEMBER_W      = QUOTIENT_BITS + 1;
   localparam int PRODUCT_W     = WEIGHT_WIDTH + MEMBER_W;
   localparam int SUM_W         = PRODUCT_W + 3;
   localparam int WSUM_W        = WEIGHT_WIDTH + 3;
   localparam int DEN_W         = WSUM_W + QUOTIENT_BITS;
   localparam int NUM_W         = SUM_W + 9;
   localparam int CODE_BITS     = 7;

   localparam int MEMBER_LATENCY  = 3 + QUOTIENT_BITS;
   localparam int COMBINE_LATENCY = 4 + CODE_BITS;
   localparam int TOTAL_LATENCY   = 1 + MEMBER_LATENCY + COMBINE_LATENCY;

   localparam logic [1:0] KIND_ZERO = 2'd0;
   localparam logic [1:0] KIND_ONE  = 2'd1;
   localparam logic [1:0] KIND_DIV  = 2'd2;

   localparam logic [CODE_BITS-1:0] CODE_NONE   = 7'd0;
   localparam logic [CODE_BITS-1:0] CODE_OFFSET = 7'd2;
   localparam logic [CODE_BITS-1:0] CODE_FULL   = 7'd100;

   typedef struct packed {
      logic valid;
      logic active;
   } lane_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fcl_member.sv =====
// ---------------------------------------------------------------------------
// fcl_member
// Ramp membership of one feature: level offset, classify, pipelined divide.
// ---------------------------------------------------------------------------
`default_nettype none

module fcl_member
   import fcl_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lane_ctl_type                  in_ctl,
   input  wire logic signed [VAL_W-1:0]       in_value,
   input  wire logic signed [LEVEL_WIDTH-1:0] base_level,
   input  wire logic signed [LEVEL_WIDTH-1:0] full_level,
   output lane_ctl_type                       out_ctl,
   output logic [MEMBER_W-1:0]                out_member
);

   lane_ctl_type              c0_ff, c1_ff;
   logic signed [VAL_W-1:0]   val0_ff;
   logic signed [DIFF_W-1:0]  d_ff;
   logic signed [SPAN_W-1:0]  span_ff;

   lane_ctl_type              ctl_ff  [QUOTIENT_BITS+1];
   logic [1:0]                kind_ff [QUOTIENT_BITS+1];
   logic [SPAN_W-1:0]         div_ff  [QUOTIENT_BITS+1];
   logic [SPAN_W-1:0]         rem_ff  [QUOTIENT_BITS+1];
   logic [QUOTIENT_BITS-1:0]  q_ff    [QUOTIENT_BITS+1];

   logic [DIFF_W-1:0] ad;
   logic [SPAN_W-1:0] as;
   logic [1:0]        kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         c0_ff <= '0;
         c1_ff <= '0;
      end else begin
         c0_ff <= in_ctl;
         c1_ff <= c0_ff;
      end
      val0_ff <= in_value;
      d_ff    <= DIFF_W'(val0_ff) - DIFF_W'(base_level);
      span_ff <= SPAN_W'(full_level) - SPAN_W'(base_level);
   end

   always_comb begin
      ad = d_ff[DIFF_W-1] ? DIFF_W'(-d_ff) : DIFF_W'(d_ff);
      as = span_ff[SPAN_W-1] ? SPAN_W'(-span_ff) : SPAN_W'(span_ff);
      if (as <= SPAN_W'(SMALL_LIMIT) || d_ff == '0 ||
          d_ff[DIFF_W-1] != span_ff[SPAN_W-1]) begin
         kind_in = KIND_ZERO;
      end else if (ad >= DIFF_W'(as)) begin
         kind_in = KIND_ONE;
      end else begin
         kind_in = KIND_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else begin
         ctl_ff[0] <= c1_ff;
      end
      kind_ff[0] <= kind_in;
      div_ff[0]  <= as;
      rem_ff[0]  <= ad[SPAN_W-1:0];
      q_ff[0]    <= '0;
   end

   for (genvar j = 0; j < QUOTIENT_BITS; j++) begin : g_div
      logic [SPAN_W:0] twice;
      logic            take;
      assign twice = {rem_ff[j], 1'b0};
      assign take  = twice >= {1'b0, div_ff[j]};
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j+1] <= '0;
         end else begin
            ctl_ff[j+1] <= ctl_ff[j];
         end
         kind_ff[j+1] <= kind_ff[j];
         div_ff[j+1]  <= div_ff[j];
         rem_ff[j+1]  <= take ? SPAN_W'(twice - {1'b0, div_ff[j]}) : twice[SPAN_W-1:0];
         q_ff[j+1]    <= {q_ff[j][QUOTIENT_BITS-2:0], take};
      end
   end

   assign out_ctl = ctl_ff[QUOTIENT_BITS];

   always_comb begin
      unique case (kind_ff[QUOTIENT_BITS])
         KIND_ONE: out_member = MEMBER_W'(1) << QUOTIENT_BITS;
         KIND_DIV: out_member = {1'b0, q_ff[QUOTIENT_BITS]};
         default:  out_member = '0;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fcl_combine.sv =====
// ---------------------------------------------------------------------------
// fcl_combine
// Weighted sum, normalization divide and likelihood code.
// ---------------------------------------------------------------------------
`default_nettype none

module fcl_combine
   import fcl_pkg::*;
(
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire lane_ctl_type [NUM_FEATURES-1:0]           lane_ctl,
   input  wire logic [NUM_FEATURES-1:0][MEMBER_W-1:0]     member,
   input  wire logic [NUM_FEATURES-1:0][WEIGHT_WIDTH-1:0] weight,
   output logic                                           out_valid,
   output logic [CODE_BITS-1:0]                           out_code
);

   logic                                   m_valid_ff;
   logic [NUM_FEATURES-1:0][PRODUCT_W-1:0] prod_ff;
   logic [NUM_FEATURES-1:0][WEIGHT_WIDTH-1:0] wt_ff;

   logic              s_valid_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [WSUM_W-1:0] wsum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [WSUM_W-1:0] wsum_in;

   logic              p_valid_ff [CODE_BITS+1];
   logic              none_ff    [CODE_BITS+1];
   logic              over_ff    [CODE_BITS+1];
   logic [NUM_W-1:0]  rem_ff     [CODE_BITS+1];
   logic [NUM_W-1:0]  den2_ff    [CODE_BITS+1];
   logic [CODE_BITS-1:0] q_ff    [CODE_BITS+1];
   logic [DEN_W-1:0]  den;

   logic                 valid_ff;
   logic [CODE_BITS-1:0] code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= lane_ctl[0].valid;
      end
      for (int k = 0; k < NUM_FEATURES; k++) begin
         prod_ff[k] <= lane_ctl[k].active ?
                       PRODUCT_W'(weight[k]) * PRODUCT_W'(member[k]) : '0;
         wt_ff[k]   <= lane_ctl[k].active ? weight[k] : '0;
      end
   end

   always_comb begin
      sum_in  = '0;
      wsum_in = '0;
      for (int k = 0; k < NUM_FEATURES; k++) begin
         sum_in  = sum_in + SUM_W'(prod_ff[k]);
         wsum_in = wsum_in + WSUM_W'(wt_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= m_valid_ff;
      end
      sum_ff  <= sum_in;
      wsum_ff <= wsum_in;
   end

   assign den = {wsum_ff, {QUOTIENT_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff[0] <= 1'b0;
      end else begin
         p_valid_ff[0] <= s_valid_ff;
      end
      none_ff[0] <= wsum_ff == '0;
      over_ff[0] <= NUM_W'(sum_ff) > NUM_W'(den);
      rem_ff[0]  <= NUM_W'(NUM_W'(sum_ff) * NUM_W'(200)) + NUM_W'(den);
      den2_ff[0] <= NUM_W'({den, 1'b0});
      q_ff[0]    <= '0;
   end

   for (genvar i = 0; i < CODE_BITS; i++) begin : g_div
      localparam int SH = CODE_BITS - 1 - i;
      logic [NUM_W-1:0] shifted;
      logic             take;
      assign shifted = den2_ff[i] << SH;
      assign take    = rem_ff[i] >= shifted;
      always_ff @(posedge clock) begin
         if (reset) begin
            p_valid_ff[i+1] <= 1'b0;
         end else begin
            p_valid_ff[i+1] <= p_valid_ff[i];
         end
         none_ff[i+1] <= none_ff[i];
         over_ff[i+1] <= over_ff[i];
         den2_ff[i+1] <= den2_ff[i];
         rem_ff[i+1]  <= take ? rem_ff[i] - shifted : rem_ff[i];
         q_ff[i+1]    <= {q_ff[i][CODE_BITS-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= p_valid_ff[CODE_BITS];
      end
      priority if (none_ff[CODE_BITS]) begin
         code_ff <= CODE_NONE;
      end else if (over_ff[CODE_BITS]) begin
         code_ff <= CODE_FULL + CODE_OFFSET;
      end else begin
         code_ff <= q_ff[CODE_BITS] + CODE_OFFSET;
      end
   end

   assign out_valid = valid_ff;
   assign out_code  = code_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fuzzy_clutter_likelihood.sv =====
// ---------------------------------------------------------------------------
// fuzzy_clutter_likelihood
// Clutter likelihood of one radar bin from six weighted ramp memberships.
// ---------------------------------------------------------------------------
// Use: load the six feature settings through the csr_ write channel (index
// 0..5, csr_ready is always high, other indexes are dropped) while no bin is
// in flight. Present a bin on the req_ ports with start high; busy is never
// raised, so one beat is taken every clock cycle.
// Each beat comes out on rsp_likelihood_code with rsp_valid high for one
// cycle, in order. The path runs through the membership divider (one
// quotient bit per stage, 16 stages) and the normalization divider (one
// code bit per stage, 7 stages) plus the input, offset, classify,
// multiply, sum and output registers.
// Throughput: one bin per cycle.
// Reset clears the settings to 0 and empties the pipeline; bins in flight
// are dropped. The receiver cannot stall, so nothing ever holds the stream.
// ---------------------------------------------------------------------------
`default_nettype none

module fuzzy_clutter_likelihood
   import fcl_pkg::*;
(
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic signed [FEATURE_WIDTH-1:0] req_texture,
   input  wire logic signed [FEATURE_WIDTH-1:0] req_sign_value,
   input  wire logic signed [FEATURE_WIDTH-1:0] req_spin,
   input  wire logic signed [FEATURE_WIDTH-1:0] req_velocity_mean,
   input  wire logic signed [FEATURE_WIDTH-1:0] req_velocity_spread,
   input  wire logic signed [FEATURE_WIDTH-1:0] req_width_mean,
   input  wire logic                            req_reflectivity_valid,
   input  wire logic                            req_spin_valid,
   input  wire logic                            req_doppler_valid,
   output logic                                 rsp_valid,
   output logic [CODE_BITS-1:0]                 rsp_likelihood_code,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]      csr_index,
   input  wire logic [SETTING_WIDTH-1:0]        csr_data
);

   logic [SETTING_WIDTH-1:0] setting_ff [NUM_FEATURES];

   logic                            in_valid_ff;
   logic                            zv_ff, pv_ff, dv_ff;
   logic signed [FEATURE_WIDTH-1:0] feat_ff [NUM_FEATURES];

   logic signed [VAL_W-1:0] value   [NUM_FEATURES];
   logic signed [VAL_W-1:0] sgn_ext, spin_off, vel_ext;
   lane_ctl_type            lane_in [NUM_FEATURES];

   lane_ctl_type [NUM_FEATURES-1:0]             lane_out;
   logic [NUM_FEATURES-1:0][MEMBER_W-1:0]       member;
   logic [NUM_FEATURES-1:0][WEIGHT_WIDTH-1:0]   weight;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_FEATURES; k++) begin
            setting_ff[k] <= '0;
         end
      end else if (csr_valid && csr_index < CSR_INDEX_WIDTH'(NUM_FEATURES)) begin
         setting_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
      zv_ff      <= req_reflectivity_valid;
      pv_ff      <= req_reflectivity_valid && req_spin_valid;
      dv_ff      <= req_doppler_valid;
      feat_ff[0] <= req_texture;
      feat_ff[1] <= req_sign_value;
      feat_ff[2] <= req_spin;
      feat_ff[3] <= req_velocity_mean;
      feat_ff[4] <= req_velocity_spread;
      feat_ff[5] <= req_width_mean;
   end

   always_comb begin
      sgn_ext  = VAL_W'(feat_ff[1]);
      spin_off = VAL_W'(feat_ff[2]) - VAL_W'(FIFTY_LEVEL);
      vel_ext  = VAL_W'(feat_ff[3]);
      value[0] = VAL_W'(feat_ff[0]);
      value[1] = sgn_ext[VAL_W-1] ? -sgn_ext : sgn_ext;
      value[2] = spin_off[VAL_W-1] ? -spin_off : spin_off;
      value[3] = vel_ext[VAL_W-1] ? -vel_ext : vel_ext;
      value[4] = VAL_W'(feat_ff[4]);
      value[5] = VAL_W'(feat_ff[5]);
      lane_in[0] = '{valid: in_valid_ff, active: zv_ff};
      lane_in[1] = '{valid: in_valid_ff, active: zv_ff};
      lane_in[2] = '{valid: in_valid_ff, active: pv_ff};
      lane_in[3] = '{valid: in_valid_ff, active: dv_ff};
      lane_in[4] = '{valid: in_valid_ff, active: dv_ff};
      lane_in[5] = '{valid: in_valid_ff, active: dv_ff};
   end

   for (genvar k = 0; k < NUM_FEATURES; k++) begin : g_lane
      assign weight[k] = setting_ff[k][2*LEVEL_WIDTH +: WEIGHT_WIDTH];
      fcl_member u_member (
         .clock      (clock),
         .reset      (reset),
         .in_ctl     (lane_in[k]),
         .in_value   (value[k]),
         .base_level ($signed(setting_ff[k][LEVEL_WIDTH-1:0])),
         .full_level ($signed(setting_ff[k][LEVEL_WIDTH +: LEVEL_WIDTH])),
         .out_ctl    (lane_out[k]),
         .out_member (member[k])
      );
   end

   fcl_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .lane_ctl  (lane_out),
      .member    (member),
      .weight    (weight),
      .out_valid (rsp_valid),
      .out_code  (rsp_likelihood_code)
   );

`include "fuzzy_clutter_likelihood_assert.svh"

   `FCL_ASSERT_IMPL(a_rsp_from_req, clock, reset, rsp_valid,
                    $past(start, TOTAL_LATENCY), "result without a request beat")
   `FCL_ASSERT_IMPL(a_code_range, clock, reset, rsp_valid,
                    rsp_likelihood_code == CODE_NONE ||
                    (rsp_likelihood_code >= CODE_OFFSET &&
                     rsp_likelihood_code <= CODE_FULL + CODE_OFFSET),
                    "likelihood code out of range")
   `FCL_ASSERT_NEXT(a_lanes_aligned, clock, reset, in_valid_ff,
                    lane_out[0].valid == lane_out[NUM_FEATURES-1].valid,
                    "lanes out of step")

endmodule

`default_nettype wire

// ===== sim/fuzzy_clutter_likelihood_tb.sv =====
// ---------------------------------------------------------------------------
// fuzzy_clutter_likelihood_tb
// Drives radar bins through the clutter likelihood block and checks every
// code against a fixed expected code or an in-bench predictor of the six
// weighted ramp memberships, over several sets of feature settings loaded between phases.
// ---------------------------------------------------------------------------
`default_nettype none

module fuzzy_clutter_likelihood_tb;
   import fcl_pkg::*;

   localparam int DRAIN_CYCLES = TOTAL_LATENCY + 8;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_BINS  = 1250;

   typedef logic signed [FEATURE_WIDTH-1:0] feat_type;

   typedef struct {
      feat_type            f[NUM_FEATURES];
      logic                zv, pv, dv;
      int                  code;   // -1: predict
   } bin_type;

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid, csr_valid = 0, csr_ready;
   logic [CODE_BITS-1:0] rsp_likelihood_code;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [SETTING_WIDTH-1:0]   csr_data = '0;
   feat_type req_f[NUM_FEATURES];
   logic req_zv = 0, req_pv = 0, req_dv = 0;

   logic [SETTING_WIDTH-1:0] setting_shadow[NUM_FEATURES];
   logic [CODE_BITS-1:0]     code_queue[$];
   int errors = 0, bins_sent = 0, codes_seen = 0, idle_cycles = 0;
   int send_idle_pct = 0;
   bit timed_out = 0;

   always #5 clock = ~clock;

   initial for (int k = 0; k < NUM_FEATURES; k++) req_f[k] = '0;

   fuzzy_clutter_likelihood u_dut (
      .clock, .reset, .start, .busy,
      .req_texture(req_f[0]), .req_sign_value(req_f[1]), .req_spin(req_f[2]),
      .req_velocity_mean(req_f[3]), .req_velocity_spread(req_f[4]),
      .req_width_mean(req_f[5]),
      .req_reflectivity_valid(req_zv), .req_spin_valid(req_pv),
      .req_doppler_valid(req_dv),
      .rsp_valid, .rsp_likelihood_code,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   function automatic longint unsigned ramp_member(longint value,
                                                   logic [63:0] s);
      longint zero, full, span, d;
      longint unsigned ad, as;
      zero = longint'(signed'(s[23:0]));
      full = longint'(signed'(s[47:24]));
      span = full - zero;
      d = value - zero;
      as = span < 0 ? -span : span;
      ad = d < 0 ? -d : d;
      if (as * 100 <= (64'd1 << FEATURE_FRACTION_BITS)) return 0;
      if (d == 0 || ((d < 0) != (span < 0))) return 0;
      if (ad >= as) return 65536;
      return (ad * 65536) / as;
   endfunction

   function automatic logic [CODE_BITS-1:0] predict_code(bin_type b);
      longint v[NUM_FEATURES];
      bit on[NUM_FEATURES];
      longint unsigned sum, wsum, den, w, code;
      sum = 0; wsum = 0;
      for (int k = 0; k < NUM_FEATURES; k++) v[k] = longint'(b.f[k]);
      v[1] = v[1] < 0 ? -v[1] : v[1];
      v[2] = v[2] - (longint'(50) << FEATURE_FRACTION_BITS);
      v[2] = v[2] < 0 ? -v[2] : v[2];
      v[3] = v[3] < 0 ? -v[3] : v[3];
      on = '{b.zv, b.zv, b.zv & b.pv, b.dv, b.dv, b.dv};
      for (int k = 0; k < NUM_FEATURES; k++)
         if (on[k]) begin
            w = setting_shadow[k][63:48];
            sum += w * ramp_member(v[k], setting_shadow[k]);
            wsum += w;
         end
      if (wsum == 0) return CODE_NONE;
      den = wsum * 65536;
      code = (sum > den) ? 100 : (200 * sum + den) / (2 * den);
      return CODE_BITS'(code + 2);
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            codes_seen++;
            if (code_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected code, expected none, actual %0d",
                        $time, rsp_likelihood_code);
            end else begin
               if (rsp_likelihood_code !== code_queue[0]) begin
                  errors++;
                  $display("%0t: likelihood_code mismatch, expected %0d, actual %0d",
                           $time, code_queue[0], rsp_likelihood_code);
               end
               void'(code_queue.pop_front());
            end
         end
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("%0t: watchdog expired", $time);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // hold valid across a run of writes; the caller drops it after the last
   task automatic write_setting(int idx, logic [63:0] value);
      csr_valid <= 1;
      csr_index <= CSR_INDEX_WIDTH'(idx);
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      setting_shadow[idx] = value;
   endtask

   task automatic drain_pipe();
      while (code_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_bin(bin_type b);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      for (int k = 0; k < NUM_FEATURES; k++) req_f[k] <= b.f[k];
      req_zv <= b.zv; req_pv <= b.pv; req_dv <= b.dv;
      do @(posedge clock); while (busy);
      code_queue.push_back(b.code >= 0 ? CODE_BITS'(b.code) : predict_code(b));
      bins_sent++;
   endtask

   function automatic logic [63:0] pack_setting(int zero, int full, int w);
      return {16'(w), 24'(full), 24'(zero)};
   endfunction

   function automatic logic [63:0] random_setting();
      int zero, full;
      zero = $urandom_range(1) ? int'($urandom_range(8191)) - 4096
                               : int'(signed'(24'($urandom)));
      full = $urandom_range(3) ? zero + int'($urandom_range(16383)) - 8192
                               : int'(signed'(24'($urandom)));
      if ($urandom_range(9) == 0) full = zero + int'($urandom_range(80)) - 40;
      return pack_setting(zero, full, $urandom_range(7) ? $urandom : 0);
   endfunction

   function automatic bin_type random_bin();
      bin_type b;
      for (int k = 0; k < NUM_FEATURES; k++)
         b.f[k] = $urandom_range(3) ? feat_type'(int'($urandom_range(16383)) - 8192)
                                    : feat_type'($urandom);
      if ($urandom_range(3) == 0)
         b.f[2] = feat_type'(FIFTY_LEVEL + int'($urandom_range(8191)) - 4096);
      b.zv = 1'($urandom_range(1));
      b.pv = 1'($urandom_range(1));
      b.dv = 1'($urandom_range(1));
      b.code = -1;
      return b;
   endfunction

   function automatic bin_type mk(int t, int sg, int sp, int vm, int vs, int wm,
                                  bit zv, bit pv, bit dv, int code);
      bin_type b;
      b.f = '{feat_type'(t), feat_type'(sg), feat_type'(sp), feat_type'(vm),
              feat_type'(vs), feat_type'(wm)};
      b.zv = zv; b.pv = pv; b.dv = dv; b.code = code;
      return b;
   endfunction

   localparam int ONE  = 1 << FEATURE_FRACTION_BITS;
   localparam int FMAX = (1 << (FEATURE_WIDTH - 1)) - 1;
   localparam int FMIN = -(1 << (FEATURE_WIDTH - 1));

   initial begin
      bin_type directed[$];
      for (int k = 0; k < NUM_FEATURES; k++) setting_shadow[k] = '0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // no weights after reset: every code is zero
      directed.push_back(mk(FMAX, FMIN, FMAX, FMIN, FMAX, FMIN, 1, 1, 1, 0));
      directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      foreach (directed[i]) send_bin(directed[i]);
      start <= 0;
      drain_pipe();

      // ramps 0..1 on the first five features, equal weight 256; small span on width
      for (int k = 0; k < 5; k++) write_setting(k, pack_setting(0, ONE, 256));
      write_setting(5, pack_setting(0, 40, 256));
      csr_valid <= 0;
      directed.delete();
      directed.push_back(mk(0, 0, 50*ONE, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(mk(0, 0, 50*ONE, 0, 0, 0, 1, 1, 1, 2));
      directed.push_back(mk(FMAX, FMIN, FMAX, FMIN, FMAX, FMAX, 1, 1, 1, 85));
      directed.push_back(mk(ONE, ONE, 51*ONE, ONE, ONE, ONE, 1, 1, 0, 102));
      directed.push_back(mk(ONE, ONE, 49*ONE, 0, 0, 0, 1, 0, 0, 102));
      directed.push_back(mk(ONE, -ONE, 0, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(mk(ONE/2, 0, 50*ONE, 0, 0, 0, 1, 0, 0, -1));
      directed.push_back(mk(0, 0, 0, -ONE, ONE, FMAX, 0, 0, 1, -1));
      directed.push_back(mk(-ONE, FMIN, FMIN, FMAX, -1, 1, 1, 1, 1, -1));
      directed.push_back(mk(ONE/3, ONE/7, 50*ONE+ONE/5, ONE/9, 1, 0, 1, 1, 1, -1));
      foreach (directed[i]) send_bin(directed[i]);
      start <= 0;
      drain_pipe();

      // falling ramps, extreme levels and weights
      write_setting(0, pack_setting(ONE, 0, 16'hFFFF));
      write_setting(1, pack_setting(FMAX, FMIN, 1));
      write_setting(2, pack_setting(FMIN, FMAX, 16'hFFFF));
      write_setting(3, 64'hFFFF_FFFF_FFFF_FFFF);
      write_setting(4, pack_setting(0, 41, 300));
      write_setting(5, pack_setting(-ONE, -2*ONE, 0));
      csr_valid <= 0;
      directed.delete();
      directed.push_back(mk(ONE/2, 0, 0, ONE, -ONE, -2*ONE, 1, 1, 1, -1));
      directed.push_back(mk(2*ONE, FMAX, FMAX, FMIN, 41, -ONE, 1, 1, 1, -1));
      directed.push_back(mk(-ONE, FMIN, FMIN, 0, 40, FMIN, 1, 1, 1, -1));
      directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 1, -1));
      foreach (directed[i]) send_bin(directed[i]);

      // random phases: light sender gaps, heavy gaps with a drain, full rate
      for (int phase = 0; phase < 4; phase++) begin
         start <= 0;
         drain_pipe();
         for (int k = 0; k < NUM_FEATURES; k++) write_setting(k, random_setting());
         csr_valid <= 0;
         send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 53 : 0;
         for (int i = 0; i < RANDOM_BINS / 4; i++) begin
            if (phase == 1 && i == 100) begin
               start <= 0;
               while (code_queue.size() != 0) @(posedge clock);
            end
            send_bin(random_bin());
         end
      end
      start <= 0;
      drain_pipe();

      $display("Covered %0d bins, %0d codes: three directed setting sets with",
               bins_sent, codes_seen);
      $display("extremes, then four random sets with sender gaps and a full drain.");
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fcl_pkg.sv
hw/rtl/fcl_member.sv
hw/rtl/fcl_combine.sv
hw/rtl/fuzzy_clutter_likelihood.sv
sim/fuzzy_clutter_likelihood_tb.sv
